@@ hdl/bsqp_pkg.sv @@
`timescale 1ns / 1ps
package bsqp_pkg;
	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 240;

	localparam logic [2:0] REG_FLOOR  = 3'd0;
	localparam logic [2:0] REG_RADIUS = 3'd1;
	localparam logic [2:0] REG_GLEFT  = 3'd2;
	localparam logic [2:0] REG_GRIGHT = 3'd3;
	localparam logic [2:0] REG_GTOP   = 3'd4;
	localparam logic [2:0] REG_GBOT   = 3'd5;

	localparam logic CMD_LOAD = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCALE, ST_RADIUS, ST_CORNER, ST_MAC, ST_PREP, ST_DIV,
		ST_CHECK, ST_OUT0, ST_OUT1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;     // capture caster fields
		logic scale_go;    // compute scale
		logic radius_go;   // compute radius and height check
		logic corner_go;   // build corner, preset accumulators to the translation column
		logic mac_go;      // one multiply-accumulate step
		logic prep_go;     // saturate rows, set up divide
		logic div_go;      // one divider step
		logic store_go;    // store projected corner
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic height_bad;
		logic corner_bad;
	} status_t;
endpackage

@@ hdl/blob_shadow_quad_projector_core.sv @@
`timescale 1ns / 1ps
// blob shadow quad projector
// s_axis: one item per load or caster; tuser = cmd, tdata packs
//   entry_index, entry_value, pos_x, pos_y, pos_z, bound_size
// m_axis: two triangle items per accepted caster, tlast = last_tri
// cfg: register write channel, index 0..5, ignored beyond
// sequence: a load item is taken and the input stays ready; a caster
//   runs scale and radius, then per corner the corner setup, the
//   multiply-accumulate steps, the divide setup and the 64-step
//   restoring divider shared by x, y and depth of each corner, then
//   the check, before the first triangle is offered; the input is not
//   ready until the caster is done; a rejected caster frees it sooner
// results wait in place while m_axis_tready is low; no new item
//   is taken until both triangles leave
// reset clears the matrix to zero and the registers to defaults
module blob_shadow_quad_projector_core #(
	parameter int SCREEN_WIDTH  = bsqp_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bsqp_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [167:0]  s_axis_tdata,  // entry_index, entry_value, pos_x, pos_y, pos_z, bound_size
	input  logic          s_axis_tuser,  // cmd
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [143:0]  m_axis_tdata,  // a_x a_y a_depth b_x b_y b_depth c_x c_y c_depth
	output logic          m_axis_tlast,  // last_tri
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import bsqp_pkg::*;

	cmd_t cmd;
	status_t status;
	logic [1:0] corner_idx, mac_idx;
	logic busy, in_fire;
	logic second;
	logic [143:0] tri_data;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	bsqp_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_cmd(s_axis_tuser), .out_ready(m_axis_tready),
		.status, .cmd, .corner_idx, .mac_idx, .busy,
		.out_valid(m_axis_tvalid), .second
	);

	bsqp_datapath #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
		.clk, .arst_n, .cmd, .corner_idx, .mac_idx,
		.mat_we(in_fire && s_axis_tuser == CMD_LOAD), .mat_addr(s_axis_tdata[3:0]),
		.mat_data(s_axis_tdata[35:4]),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
		.pos_x(s_axis_tdata[67:36]), .pos_y(s_axis_tdata[99:68]),
		.pos_z(s_axis_tdata[131:100]), .bound_size(s_axis_tdata[162:132]),
		.second, .status, .tri_data
	);

	assign m_axis_tdata = tri_data;
	// second triangle of the quad
	assign m_axis_tlast = second;
endmodule

@@ hdl/bsqp_datapath.sv @@
`timescale 1ns / 1ps
module bsqp_datapath #(
	parameter int SCREEN_WIDTH  = bsqp_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = bsqp_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsqp_pkg::cmd_t       cmd,
	input  logic [1:0]           corner_idx,
	input  logic [1:0]           mac_idx,
	input  logic                 mat_we,
	input  logic [3:0]           mat_addr,
	input  logic signed [31:0]   mat_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [31:0]          cfg_data,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic [30:0]          bound_size,
	input  logic                 second,
	output bsqp_pkg::status_t    status,
	output logic [143:0]         tri_data
);
	import bsqp_pkg::*;

	localparam logic signed [63:0] KX = 64'(8 * SCREEN_WIDTH);
	localparam logic signed [63:0] KY = 64'(8 * SCREEN_HEIGHT);

	logic signed [31:0] mat_q [16];
	logic signed [31:0] floor_q;
	logic [30:0] radius_q;
	logic signed [15:0] gl_q, gr_q, gt_q, gb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
			floor_q <= '0; radius_q <= 31'd1310720;
			gl_q <= -16'sd5120; gr_q <= 16'sd10240; gt_q <= -16'sd3840; gb_q <= 16'sd7680;
		end else begin
			if (mat_we) mat_q[mat_addr] <= mat_data;
			if (cfg_we) begin
				case (cfg_idx)
					REG_FLOOR:  floor_q <= cfg_data;
					REG_RADIUS: radius_q <= cfg_data[30:0];
					REG_GLEFT:  gl_q <= cfg_data[15:0];
					REG_GRIGHT: gr_q <= cfg_data[15:0];
					REG_GTOP:   gt_q <= cfg_data[15:0];
					REG_GBOT:   gb_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// caster capture
	logic signed [31:0] px_q, py_q, pz_q;
	logic [30:0] bnd_q;
	logic [17:0] scale_q;
	logic signed [32:0] r_q;
	logic hbad_q;
	logic signed [31:0] v_q [3];
	logic signed [63:0] acc_q [4];
	logic signed [31:0] mac_v;
	logic signed [63:0] prod [4];

	// bound/80 by reciprocal: floor(b*k>>38), k=ceil(2^38/80)
	logic [68:0] recip;
	logic [30:0] q80;
	always_comb begin
		recip = 69'(bnd_q) * 69'd3435973837;
		q80 = recip[68:38];
	end

	always_comb begin
		mac_v = v_q[mac_idx];
		for (int r = 0; r < 4; r++) begin
			prod[r] = (64'(mat_q[{mac_idx, 2'(r)}]) * 64'(mac_v)) >>> 16;
		end
	end

	logic signed [63:0] rr;
	always_comb rr = 64'(radius_q) * 64'(scale_q);

	logic signed [31:0] xs, ws, ys, zs;
	// divider: three numerators, one denominator
	logic signed [63:0] dnum [3];
	logic [63:0] rem_q [3];
	logic [63:0] quo_q [3];
	logic neg_q [3];
	logic [31:0] den_q;
	logic wbad_q;
	logic [63:0] tr [3];

	// saturated clip rows and divider numerators
	always_comb begin
		xs = sat32(acc_q[0]); ys = sat32(acc_q[1]);
		zs = sat32(acc_q[2]); ws = sat32(acc_q[3]);
		dnum[0] = KX * (64'(xs) + 64'(ws));
		dnum[1] = KY * (64'(ws) - 64'(ys));
		dnum[2] = 64'sd32768 * (64'(zs) + 64'(ws));
	end

	always_comb begin
		for (int k = 0; k < 3; k++) tr[k] = {rem_q[k][62:0], quo_q[k][63]};
	end

	logic signed [63:0] sx, sy, dp;
	always_comb begin
		sx = neg_q[0] ? -$signed(quo_q[0]) - 64'(rem_q[0] != 0) : $signed(quo_q[0]);
		sy = neg_q[1] ? -$signed(quo_q[1]) - 64'(rem_q[1] != 0) : $signed(quo_q[1]);
		dp = neg_q[2] ? -$signed(quo_q[2]) - 64'(rem_q[2] != 0) : $signed(quo_q[2]);
	end

	logic [47:0] scr_q [4];
	logic cbad;
	logic [15:0] dsat;
	always_comb begin
		cbad = wbad_q || sx < 64'(gl_q) || sx > 64'(gr_q) || sy < 64'(gt_q) || sy > 64'(gb_q);
		dsat = (dp < 0) ? 16'd0 : (dp > 64'sd65535) ? 16'hffff : dp[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= pos_x; py_q <= pos_y; pz_q <= pos_z; bnd_q <= bound_size;
		end
		if (cmd.scale_go) begin
			scale_q <= (q80 < 31'd32768) ? 18'd32768 :
			           (q80 > 31'd131072) ? 18'd131072 : q80[17:0];
		end
		if (cmd.radius_go) begin
			r_q <= (bnd_q == 0) ? 33'(radius_q) : 33'(rr >>> 16);
			hbad_q <= (64'(py_q) - 64'(floor_q) < 0) ||
			          (64'(py_q) - 64'(floor_q) > 64'sd26214400);
		end
		if (cmd.corner_go) begin
			v_q[0] <= sat32(64'(px_q) + ((corner_idx == 1 || corner_idx == 2) ?
				64'(r_q) : -64'(r_q)));
			v_q[1] <= sat32(64'(floor_q) + 64'sd655);
			v_q[2] <= sat32(64'(pz_q) + (corner_idx[1] ? 64'(r_q) : -64'(r_q)));
			for (int r = 0; r < 4; r++) acc_q[r] <= 64'(mat_q[12 + r]);
		end
		if (cmd.mac_go) begin
			for (int r = 0; r < 4; r++) acc_q[r] <= acc_q[r] + prod[r];
		end
		if (cmd.prep_go) begin
			wbad_q <= ws < 32'sd65536;
			den_q <= ws;
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= dnum[k] < 0;
				quo_q[k] <= dnum[k] < 0 ? 64'(-dnum[k]) : 64'(dnum[k]);
				rem_q[k] <= '0;
			end
		end
		if (cmd.div_go) begin
			for (int k = 0; k < 3; k++) begin
				if (tr[k] >= 64'(den_q)) begin
					rem_q[k] <= tr[k] - 64'(den_q);
					quo_q[k] <= {quo_q[k][62:0], 1'b1};
				end else begin
					rem_q[k] <= tr[k];
					quo_q[k] <= {quo_q[k][62:0], 1'b0};
				end
			end
		end
		if (cmd.store_go) scr_q[corner_idx] <= {dsat, sy[15:0], sx[15:0]};
	end

	assign status.height_bad = hbad_q;
	assign status.corner_bad = cbad;
	assign tri_data = second ? {scr_q[3], scr_q[2], scr_q[0]}
	                         : {scr_q[2], scr_q[1], scr_q[0]};
endmodule

@@ hdl/bsqp_ctrl.sv @@
`timescale 1ns / 1ps
module bsqp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               in_cmd,
	input  logic               out_ready,
	input  bsqp_pkg::status_t  status,
	output bsqp_pkg::cmd_t     cmd,
	output logic [1:0]         corner_idx,
	output logic [1:0]         mac_idx,
	output logic               busy,
	output logic               out_valid,
	output logic               second
);
	import bsqp_pkg::*;

	state_t state_q, state_d;
	logic [1:0] corner_q, mac_q;
	logic [5:0] div_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_fire && in_cmd != CMD_LOAD) state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_RADIUS;
			ST_RADIUS: state_d = ST_CORNER;
			ST_CORNER: state_d = status.height_bad ? ST_IDLE : ST_MAC;
			ST_MAC:    if (mac_q == 2'd2) state_d = ST_PREP;
			ST_PREP:   state_d = ST_DIV;
			ST_DIV:    if (div_q == 6'd63) state_d = ST_CHECK;
			ST_CHECK:  state_d = status.corner_bad ? ST_IDLE :
			                     (corner_q == 2'd3) ? ST_OUT0 : ST_CORNER;
			ST_OUT0:   if (out_ready) state_d = ST_OUT1;
			ST_OUT1:   if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load_in = (state_q == ST_IDLE) && in_fire;
		cmd.scale_go = state_q == ST_SCALE;
		cmd.radius_go = state_q == ST_RADIUS;
		cmd.corner_go = state_q == ST_CORNER;
		cmd.mac_go = state_q == ST_MAC;
		cmd.prep_go = state_q == ST_PREP;
		cmd.div_go = state_q == ST_DIV;
		cmd.store_go = state_q == ST_CHECK;
		busy = state_q != ST_IDLE;
		out_valid = state_q == ST_OUT0 || state_q == ST_OUT1;
		second = state_q == ST_OUT1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; corner_q <= '0; mac_q <= '0; div_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RADIUS) corner_q <= '0;
			else if (state_q == ST_CHECK) corner_q <= corner_q + 2'd1;
			mac_q <= (state_q == ST_MAC) ? mac_q + 2'd1 : 2'd0;
			div_q <= (state_q == ST_DIV) ? div_q + 6'd1 : 6'd0;
		end
	end

	assign corner_idx = corner_q;
	assign mac_idx = mac_q;

	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT0 && out_ready) |=> state_q == ST_OUT1)
		else $error("second triangle skipped");
	a_mac: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> mac_q != 2'd3) else $error("mac overrun");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> (state_q == ST_DIV && div_q == 0))
		else $error("divider start");
endmodule

@@ tb/sv/tb_blob_shadow_quad_projector_core.sv @@
`timescale 1ns / 1ps
module tb_blob_shadow_quad_projector_core;
	import bsqp_pkg::*;

	localparam int  SCR_W      = SCREEN_WIDTH_DEF;
	localparam int  SCR_H      = SCREEN_HEIGHT_DEF;
	localparam int  DRAIN_WAIT = 320;    // longer than one caster's full run
	localparam int  HOLD_OFF   = 700;    // long receiver stall for back-pressure
	localparam int  STALL_MAX  = 6000;   // cycles without any handshake
	localparam int  ONE        = 65536;
	localparam int  MAX_H      = 400 * 65536;
	localparam logic CMD_CASTER = 1'b1;

	// dut ports
	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [167:0]  s_axis_tdata;   // entry_index, entry_value, pos_x, pos_y, pos_z, bound_size
	logic          s_axis_tuser;   // cmd
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [143:0]  m_axis_tdata;   // a_x a_y a_depth b_x b_y b_depth c_x c_y c_depth
	logic          m_axis_tlast;   // last_tri
	logic          cfg_valid;
	logic          cfg_ready;
	logic [2:0]    cfg_index;
	logic [31:0]   cfg_data;

	blob_shadow_quad_projector_core u_top (.*);

	// one expected triangle item
	typedef struct {
		logic [143:0] verts;
		logic         last;
	} shadow_tri_t;

	shadow_tri_t shadow_tri_q[$];

	// predictor state
	logic signed [31:0] mat[16];
	longint floor_y, radius_base, g_left, g_right, g_top, g_bot;

	int  errors;
	bit  rx_hold;   // request a long receiver stall
	bit  quiet;     // no idling from either side
	string field_name[9] = '{"a_x", "a_y", "a_depth", "b_x", "b_y", "b_depth",
		"c_x", "c_y", "c_depth"};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clip_row(int row, longint vx, longint vy, longint vz);
		longint acc;
		acc = longint'(mat[12 + row]);
		acc += floor_div(longint'(mat[row]) * vx, longint'(ONE));
		acc += floor_div(longint'(mat[4 + row]) * vy, longint'(ONE));
		acc += floor_div(longint'(mat[8 + row]) * vz, longint'(ONE));
		return clamp32(acc);
	endfunction

	// screen position and depth of one corner; zero when culled
	function automatic bit project_corner(longint vx, longint vy, longint vz,
			output logic [47:0] scr);
		longint x, y, z, w, sx, sy, d;
		scr = '0;
		x = clip_row(0, vx, vy, vz);
		y = clip_row(1, vx, vy, vz);
		z = clip_row(2, vx, vy, vz);
		w = clip_row(3, vx, vy, vz);
		if (w < ONE)
			return 1'b0;
		sx = floor_div(8 * SCR_W * (x + w), w);
		sy = floor_div(8 * SCR_H * (w - y), w);
		if (sx < g_left || sx > g_right || sy < g_top || sy > g_bot)
			return 1'b0;
		d = floor_div(32768 * (z + w), w);
		if (d < 0)
			d = 0;
		if (d > 65535)
			d = 65535;
		scr = {d[15:0], sy[15:0], sx[15:0]};
		return 1'b1;
	endfunction

	// update state for one accepted item and queue the triangles it yields
	function automatic void predict_quad(logic cmd, logic [167:0] d);
		longint px, py, pz, r, scale, ys, sxg, szg;
		logic [30:0] bound;
		logic [47:0] scr[4];
		shadow_tri_t t;
		if (cmd == CMD_LOAD) begin
			mat[d[3:0]] = d[35:4];
			return;
		end
		px = longint'($signed(d[67:36]));
		py = longint'($signed(d[99:68]));
		pz = longint'($signed(d[131:100]));
		bound = d[162:132];
		r = radius_base;
		if (bound != 0) begin
			scale = longint'(bound) / 80;
			if (scale < 32768)
				scale = 32768;
			if (scale > 131072)
				scale = 131072;
			r = (r * scale) >>> 16;
		end
		if (py - floor_y < 0 || py - floor_y > MAX_H)
			return;
		ys = clamp32(floor_y + 655);
		for (int i = 0; i < 4; i++) begin
			sxg = (i == 1 || i == 2) ? 1 : -1;
			szg = (i >= 2) ? 1 : -1;
			if (!project_corner(clamp32(px + sxg * r), ys, clamp32(pz + szg * r), scr[i]))
				return;
		end
		t.verts = {scr[2], scr[1], scr[0]};
		t.last  = 1'b0;
		shadow_tri_q.push_back(t);
		t.verts = {scr[3], scr[2], scr[0]};
		t.last  = 1'b1;
		shadow_tri_q.push_back(t);
	endfunction

	function automatic void model_reg(logic [2:0] idx, logic [31:0] v);
		case (idx)
			REG_FLOOR:  floor_y     = longint'($signed(v));
			REG_RADIUS: radius_base = longint'(v[30:0]);
			REG_GLEFT:  g_left      = longint'($signed(v[15:0]));
			REG_GRIGHT: g_right     = longint'($signed(v[15:0]));
			REG_GTOP:   g_top       = longint'($signed(v[15:0]));
			REG_GBOT:   g_bot       = longint'($signed(v[15:0]));
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers
	task automatic send_item(logic cmd, logic [167:0] d);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		predict_quad(cmd, d);
	endtask

	task automatic send_load(logic [3:0] idx, logic [31:0] v);
		logic [167:0] d;
		d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		d[35:0] = {v, idx};
		send_item(CMD_LOAD, d);
	endtask

	task automatic send_caster(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [30:0] b);
		send_item(CMD_CASTER, {5'b0, b, z, y, x, $urandom, 4'($urandom)});
	endtask

	// wait until the block is idle, then write one register
	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (shadow_tri_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		model_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_guard(int l, int r, int t, int b);
		write_reg(REG_GLEFT, l);
		write_reg(REG_GRIGHT, r);
		write_reg(REG_GTOP, t);
		write_reg(REG_GBOT, b);
	endtask

	// small well-behaved view matrix, corners land near the screen; noisy swaps in random entries
	task automatic load_view_matrix(bit noisy);
		for (int i = 0; i < 16; i++) begin
			int v;
			case (i)
				0, 5, 10:   v = int'($urandom_range(0, 3000)) - 1500;
				12, 13, 14: v = int'($urandom_range(0, 40000)) - 20000;
				15:         v = ONE + int'($urandom_range(0, 200000));
				3, 7, 11:   v = ($urandom_range(0, 3) == 0) ?
					int'($urandom_range(0, 100)) - 50 : 0;
				default:    v = int'($urandom_range(0, 600)) - 300;
			endcase
			if (noisy && $urandom_range(0, 7) == 0)
				v = $urandom;
			send_load(i[3:0], v);
		end
	endtask

	task automatic send_plausible_caster();
		int h, b;
		h = $urandom_range(0, 400 * 65536);
		case ($urandom_range(0, 3))
			0: b = 0;
			1: b = $urandom_range(0, 200 * 65536);
			2: b = $urandom_range(0, 100);
			default: b = $urandom & 32'h7fff_ffff;
		endcase
		send_caster(int'($urandom_range(0, 200 * 65536)) - 100 * 65536,
			32'(floor_y + h),
			int'($urandom_range(0, 200 * 65536)) - 100 * 65536, 31'(b));
	endtask

	// ---------------------------------------------------------------- receiver
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
				rx_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	// result checker, compares each triangle with the oldest expectation
	always @(posedge clk) begin
		shadow_tri_t t;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (shadow_tri_q.size() == 0) begin
				$display("%0t: unexpected triangle %h last %b", $time, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				t = shadow_tri_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (m_axis_tdata[k*16 +: 16] !== t.verts[k*16 +: 16]) begin
						$display("%0t: %s expected %h actual %h", $time, field_name[k],
							t.verts[k*16 +: 16], m_axis_tdata[k*16 +: 16]);
						errors++;
					end
				if (m_axis_tlast !== t.last) begin
					$display("%0t: last_tri expected %b actual %b", $time, t.last,
						m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	int stall_cnt;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	task automatic test_loads_and_plain_quad();
		send_load(4'd0, 32'h7fff_ffff);
		send_load(4'd15, 32'h8000_0000);
		foreach (mat[i])
			send_load(i[3:0], 0);
		send_load(4'd0, 1000);
		send_load(4'd5, 1000);
		send_load(4'd10, 1000);
		send_load(4'd15, 2 * ONE);
		send_caster(0, 10 * ONE, 0, 0);            // unscaled radius
		send_caster(0, 10 * ONE, 0, 1);            // scale clamped low
		send_caster(0, 10 * ONE, 0, 31'h7fff_ffff); // scale clamped high
		send_caster(5 * ONE, 10 * ONE, -5 * ONE, 31'(80 * ONE));
	endtask

	task automatic test_height_limits();
		send_caster(0, 0, 0, 0);                  // exactly on the floor
		send_caster(0, MAX_H, 0, 0);              // top of range
		send_caster(0, MAX_H + 1, 0, 0);          // just above
		send_caster(0, -1, 0, 0);                 // below the floor
		send_caster(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
		send_caster(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
		send_caster(32'h7fff_ffff, 5 * ONE, 32'h8000_0000, 0); // corners saturate
	endtask

	task automatic test_depth_and_w();
		send_load(4'd14, 10 * ONE);               // depth past one
		send_caster(0, 10 * ONE, 0, 0);
		send_load(4'd14, -10 * ONE);              // depth below zero
		send_caster(0, 10 * ONE, 0, 0);
		send_load(4'd14, 0);
		send_load(4'd15, ONE - 1);                // w just under one
		send_caster(0, 10 * ONE, 0, 0);
		send_load(4'd15, ONE);
		send_caster(0, 10 * ONE, 0, 0);
	endtask

	task automatic test_registers();
		write_reg(3'd6, $urandom);                // out of range, ignored
		write_reg(3'd7, $urandom);
		set_guard(10240, -5120, -3840, 7680);      // inverted x band
		send_caster(0, 10 * ONE, 0, 0);
		set_guard(-32768, 32767, -32768, 32767);
		write_reg(REG_RADIUS, 0);
		send_caster(0, 10 * ONE, 0, 0);
		write_reg(REG_RADIUS, 32'h7fff_ffff);
		send_caster(0, 10 * ONE, 0, 0);
		write_reg(REG_FLOOR, 32'h7fff_ffff);
		send_caster(0, 32'h7fff_ffff, 0, 0);
		write_reg(REG_FLOOR, 32'h8000_0000);
		send_caster(0, 32'h8000_0000, 0, 0);
		write_reg(REG_FLOOR, 0);
		write_reg(REG_RADIUS, 20 * ONE);
	endtask

	task automatic test_random(int blocks);
		for (int n = 0; n < blocks; n++) begin
			case ($urandom_range(0, 9))
				0: set_guard(-32768, 32767, -32768, 32767);
				1: set_guard($urandom, $urandom, $urandom, $urandom);
				2: set_guard(-5120, 10240, -3840, 7680);
				3: write_reg(REG_FLOOR, int'($urandom_range(0, 200 * ONE)) - 100 * ONE);
				4: write_reg(REG_RADIUS, $urandom_range(0, 50 * ONE));
				5: write_reg(REG_FLOOR, $urandom);
				default: ;
			endcase
			load_view_matrix($urandom_range(0, 4) == 0);
			repeat (20) begin
				if ($urandom_range(0, 4) == 0)
					send_item(1'($urandom_range(0, 1)),
						168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
				else
					send_plausible_caster();
			end
		end
	endtask

	task automatic test_back_pressure();
		set_guard(-32768, 32767, -32768, 32767);
		load_view_matrix(1'b0);
		rx_hold = 1'b1;
		repeat (12) send_caster(0, 10 * ONE, 0, 0);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		errors        = 0;
		rx_hold       = 1'b0;
		quiet         = 1'b0;
		foreach (mat[i])
			mat[i] = 0;
		floor_y     = 0;
		radius_base = 20 * ONE;
		g_left      = -5120;
		g_right     = 10240;
		g_top       = -3840;
		g_bot       = 7680;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_loads_and_plain_quad();
		test_height_limits();
		test_depth_and_w();
		test_registers();
		test_random(45);
		test_back_pressure();
		quiet = 1'b1;
		test_random(4);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (shadow_tri_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
